FILE: sv/agdm_pkg.sv
// package for the audio gain, dc blocker and level meter
// holds widths, constants, sequencer states and shared helper functions
// no dependencies
package agdm_pkg;

  localparam int unsigned MAX_CHANNELS    = 8;
  localparam int unsigned MAX_CHUNK       = 4096;
  localparam int unsigned GAIN_FRAC_BITS  = 14;
  localparam int unsigned ALPHA_FRAC_BITS = 16;

  localparam int unsigned CH_W     = $clog2(MAX_CHANNELS);
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned GAIN_W   = 20;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned CHANS_W  = 4;
  localparam int unsigned FMT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // blocker state width and meter widths
  localparam int unsigned Y_W     = 50;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned PEAK_W  = 15;
  localparam int unsigned SUM_W   = 63;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned FRAME_W = 48;

  localparam int unsigned OUT_DATA_W = 176;

  localparam logic signed [PROD_W-1:0] Y_MAX = (PROD_W'(1) <<< (Y_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] Y_MIN = -Y_MAX - PROD_W'(1);

  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

  typedef enum logic [1:0] {
    FMT_16 = 2'd0,
    FMT_24 = 2'd1,
    FMT_32 = 2'd2
  } fmt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT   = 3'd0,
    CFG_CHANNELS = 3'd1,
    CFG_DOWNMIX  = 3'd2,
    CFG_GAIN     = 3'd3,
    CFG_DC_EN    = 3'd4,
    CFG_DC_ALPHA = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_GSAT,
    S_FBLO,
    S_ACC,
    S_DCOUT,
    S_SQ,
    S_METER,
    S_EMIT
  } state_e;

  // sign extend a raw word from the configured sample width
  function automatic logic signed [SAMPLE_W-1:0] sext_fmt(input logic [SAMPLE_W-1:0] raw,
                                                          input logic [FMT_W-1:0] fmt);
    logic signed [SAMPLE_W-1:0] r;
    case (fmt)
      FMT_16:  r = {{16{raw[15]}}, raw[15:0]};
      FMT_24:  r = {{8{raw[23]}}, raw[23:0]};
      default: r = raw;
    endcase
    return r;
  endfunction

  // arithmetic shift right rounding toward zero
  function automatic logic signed [PROD_W-1:0] trunc_shr(input logic signed [PROD_W-1:0] v,
                                                         input int unsigned sh);
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] s;
    bias = v[PROD_W-1] ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
    s    = v + bias;
    return s >>> sh;
  endfunction

  // saturate to the configured sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_fmt(input logic signed [PROD_W-1:0] v,
                                                         input logic [FMT_W-1:0] fmt);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    logic signed [PROD_W-1:0] r;
    case (fmt)
      FMT_16:  hi = PROD_W'(32767);
      FMT_24:  hi = PROD_W'(8388607);
      default: hi = PROD_W'(2147483647);
    endcase
    lo = -hi - PROD_W'(1);
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: sv/audio_gain_dc_block_meter.sv
// top level of the audio gain, dc blocker and level meter
// sequencer, config registers, filter history and meter around one shared multiplier
// depends on agdm_pkg and agdm_mul
//
// Takes one interleaved PCM word at a time and handles it under a small
// sequencer that drives a single registered multiplier (34 x 25 bits signed),
// so s_axis_tready is high only while the sequencer is idle; no new word is
// taken before the last is through. With the dc blocker off a kept sample
// steps through gain, saturate, square, accumulate and emit; with it on, two
// more multiplies for the pole feedback plus the blocker sum and its
// saturation come in too. A dropped sample that ends a chunk goes straight
// to emit, and one with no chunk end gives no output word. The result sits
// in an output register, so a stalled m_axis_tready holds only the emit step
// and not the word already waiting. Writing dc_enable = 0 clears the blocker
// history of all channels at once. Config is to be written by the user only
// while the block is idle; the block itself does not enforce this.
module audio_gain_dc_block_meter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write port
  input  logic                                  cfg_we_i,
  input  logic [agdm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [agdm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [31:0]                           s_axis_tdata,  // [31:0] sample_in
  input  logic [2:0]                            s_axis_tuser,  // [2:0] channel_index
  input  logic                                  s_axis_tlast,  // chunk_last
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] sample_out, [46:32] peak_level, [109:47] sum_squares,
  // [122:110] metered_count, [170:123] frames_total, [175:171] zero
  output logic [agdm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tuser,  // [0] sample_valid
  output logic                                  m_axis_tlast   // chunk_done
);

  localparam int unsigned CW = agdm_pkg::CH_W;
  localparam int unsigned PW = agdm_pkg::PROD_W;

  // ---------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------
  logic [agdm_pkg::FMT_W-1:0]    fmt_q;
  logic [agdm_pkg::CHANS_W-1:0]  chans_q;
  logic                          downmix_q;
  logic [agdm_pkg::GAIN_W-1:0]   gain_q;
  logic                          dc_en_q;
  logic [agdm_pkg::ALPHA_W-1:0]  alpha_q;
  logic                          hist_clr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= agdm_pkg::FMT_16;
      chans_q   <= 4'd2;
      downmix_q <= 1'b0;
      gain_q    <= 20'd16384;
      dc_en_q   <= 1'b0;
      alpha_q   <= 16'd65208;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        agdm_pkg::CFG_FORMAT:   fmt_q     <= cfg_data_i[agdm_pkg::FMT_W-1:0];
        agdm_pkg::CFG_CHANNELS: chans_q   <= cfg_data_i[agdm_pkg::CHANS_W-1:0];
        agdm_pkg::CFG_DOWNMIX:  downmix_q <= cfg_data_i[0];
        agdm_pkg::CFG_GAIN:     gain_q    <= cfg_data_i[agdm_pkg::GAIN_W-1:0];
        agdm_pkg::CFG_DC_EN:    dc_en_q   <= cfg_data_i[0];
        agdm_pkg::CFG_DC_ALPHA: alpha_q   <= cfg_data_i[agdm_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // disabling the blocker wipes its history
  assign hist_clr = cfg_we_i && (cfg_idx_i == agdm_pkg::CFG_DC_EN) && !cfg_data_i[0];

  // effective channel count: zero acts as one, above eight acts as eight
  logic [agdm_pkg::CHANS_W-1:0] chans_eff;
  always_comb begin
    if (chans_q == '0) begin
      chans_eff = 4'd1;
    end else if (chans_q > 4'(agdm_pkg::MAX_CHANNELS)) begin
      chans_eff = 4'(agdm_pkg::MAX_CHANNELS);
    end else begin
      chans_eff = chans_q;
    end
  end

  // ---------------------------------------------------------------
  // handshake and item capture
  // ---------------------------------------------------------------
  agdm_pkg::state_e state_q, state_d;

  logic in_acc;
  logic in_kept;
  logic frame_end;

  assign s_axis_tready = (state_q == agdm_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_kept   = !(downmix_q && (chans_eff >= 4'd2) && (s_axis_tuser != '0));
  assign frame_end = ({1'b0, s_axis_tuser} == (chans_eff - 4'd1));

  logic signed [31:0] x_q;
  logic [CW-1:0]      ch_q;
  logic               last_q;
  logic               kept_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= agdm_pkg::sext_fmt(s_axis_tdata, fmt_q);
      ch_q   <= s_axis_tuser;
      last_q <= s_axis_tlast;
      kept_q <= in_kept;
    end
  end

  // frame counter advances on the last channel of a frame, kept or not
  logic [agdm_pkg::FRAME_W-1:0] frames_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
    end else if (in_acc && frame_end) begin
      frames_q <= frames_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // shared multiplier
  // ---------------------------------------------------------------
  logic signed [agdm_pkg::MUL_A_W-1:0] mul_a;
  logic signed [agdm_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]                prod;

  agdm_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------------------------------------------------------
  // blocker history per channel
  // ---------------------------------------------------------------
  logic signed [31:0]                 pin_q  [agdm_pkg::MAX_CHANNELS];
  logic signed [agdm_pkg::Y_W-1:0]    pout_q [agdm_pkg::MAX_CHANNELS];
  logic signed [31:0]                 g_q;
  logic signed [PW-1:0]               acc_q;
  logic signed [PW-1:0]               acc_sum;
  logic signed [PW-1:0]               acc_sat;

  // full blocker sum with the low feedback term, clamped to the history width
  always_comb begin
    acc_sum = acc_q + (prod >>> agdm_pkg::ALPHA_FRAC_BITS);
    if (acc_sum > agdm_pkg::Y_MAX) begin
      acc_sat = agdm_pkg::Y_MAX;
    end else if (acc_sum < agdm_pkg::Y_MIN) begin
      acc_sat = agdm_pkg::Y_MIN;
    end else begin
      acc_sat = acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < agdm_pkg::MAX_CHANNELS; i++) begin
        pin_q[i]  <= '0;
        pout_q[i] <= '0;
      end
    end else if (hist_clr) begin
      for (int i = 0; i < agdm_pkg::MAX_CHANNELS; i++) begin
        pin_q[i]  <= '0;
        pout_q[i] <= '0;
      end
    end else if (state_q == agdm_pkg::S_ACC) begin
      pin_q[ch_q]  <= g_q;
      pout_q[ch_q] <= acc_sat[agdm_pkg::Y_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // datapath and meter
  // ---------------------------------------------------------------
  logic signed [31:0]           y_q;
  logic signed [31:0]           met;
  logic signed [31:0]           met_abs;
  logic [agdm_pkg::MAG_W-1:0]   mag;
  logic signed [PW-1:0]         diff;
  logic [63:0]                  sum_next;

  logic [agdm_pkg::MAG_W-1:0]   peak_q;
  logic [agdm_pkg::SUM_W-1:0]   sum_q;
  logic [agdm_pkg::COUNT_W-1:0] count_q;

  // 32 bit samples are metered on their top half
  assign met     = fmt_q[1] ? (y_q >>> 16) : y_q;
  assign met_abs = met[31] ? -met : met;
  assign mag     = met_abs[agdm_pkg::MAG_W-1:0];

  assign diff     = PW'(g_q) - PW'(pin_q[ch_q]);
  assign sum_next = {1'b0, sum_q} + 64'(prod[2*agdm_pkg::MAG_W-1:0]);

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      agdm_pkg::S_GAIN: begin
        mul_a = agdm_pkg::MUL_A_W'(x_q);
        mul_b = {5'b0, gain_q};
      end
      agdm_pkg::S_GSAT: begin
        // alpha times the whole part of the previous output
        mul_a = pout_q[ch_q][agdm_pkg::Y_W-1:agdm_pkg::ALPHA_FRAC_BITS];
        mul_b = {9'b0, alpha_q};
      end
      agdm_pkg::S_FBLO: begin
        // alpha times the fraction part
        mul_a = {18'b0, pout_q[ch_q][agdm_pkg::ALPHA_FRAC_BITS-1:0]};
        mul_b = {9'b0, alpha_q};
      end
      agdm_pkg::S_SQ: begin
        mul_a = {10'b0, mag};
        mul_b = {1'b0, mag};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      agdm_pkg::S_IDLE: begin
        if (in_acc && !in_kept) begin
          y_q <= '0;
        end
      end
      agdm_pkg::S_GSAT: begin
        g_q <= agdm_pkg::sat_fmt(agdm_pkg::trunc_shr(prod, agdm_pkg::GAIN_FRAC_BITS), fmt_q);
        y_q <= agdm_pkg::sat_fmt(agdm_pkg::trunc_shr(prod, agdm_pkg::GAIN_FRAC_BITS), fmt_q);
      end
      agdm_pkg::S_FBLO: begin
        acc_q <= (diff <<< agdm_pkg::ALPHA_FRAC_BITS) + prod;
      end
      agdm_pkg::S_ACC: begin
        acc_q <= acc_sat;
      end
      agdm_pkg::S_DCOUT: begin
        y_q <= agdm_pkg::sat_fmt(agdm_pkg::trunc_shr(acc_q, agdm_pkg::ALPHA_FRAC_BITS), fmt_q);
      end
      default: ;
    endcase
  end

  // output register
  logic                           out_vld_q;
  logic                           out_load;
  logic [31:0]                    out_sample_q;
  logic                           out_kept_q;
  logic                           out_last_q;
  logic [agdm_pkg::PEAK_W-1:0]    out_peak_q;
  logic [agdm_pkg::SUM_W-1:0]     out_sum_q;
  logic [agdm_pkg::COUNT_W-1:0]   out_count_q;
  logic [agdm_pkg::FRAME_W-1:0]   out_frames_q;

  assign out_load = (state_q == agdm_pkg::S_EMIT) && (!out_vld_q || m_axis_tready);

  // chunk accumulators, cleared when a chunk end word is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (out_load && last_q) begin
      peak_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (state_q == agdm_pkg::S_SQ) begin
      if (mag > peak_q) begin
        peak_q <= mag;
      end
    end else if (state_q == agdm_pkg::S_METER) begin
      sum_q <= sum_next[63] ? '1 : sum_next[agdm_pkg::SUM_W-1:0];
      if (count_q < agdm_pkg::COUNT_W'(agdm_pkg::MAX_CHUNK)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= y_q;
      out_kept_q   <= kept_q;
      out_last_q   <= last_q;
      out_frames_q <= frames_q;
      if (last_q) begin
        out_peak_q  <= (peak_q > agdm_pkg::MAG_W'(agdm_pkg::PEAK_MAX)) ?
                       agdm_pkg::PEAK_MAX : peak_q[agdm_pkg::PEAK_W-1:0];
        out_sum_q   <= sum_q;
        out_count_q <= count_q;
      end else begin
        out_peak_q  <= '0;
        out_sum_q   <= '0;
        out_count_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kept_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'b0, out_frames_q, out_count_q, out_sum_q, out_peak_q, out_sample_q};

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= agdm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      agdm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_kept) begin
            state_d = agdm_pkg::S_GAIN;
          end else if (s_axis_tlast) begin
            state_d = agdm_pkg::S_EMIT;
          end
        end
      end
      agdm_pkg::S_GAIN:  state_d = agdm_pkg::S_GSAT;
      agdm_pkg::S_GSAT:  state_d = dc_en_q ? agdm_pkg::S_FBLO : agdm_pkg::S_SQ;
      agdm_pkg::S_FBLO:  state_d = agdm_pkg::S_ACC;
      agdm_pkg::S_ACC:   state_d = agdm_pkg::S_DCOUT;
      agdm_pkg::S_DCOUT: state_d = agdm_pkg::S_SQ;
      agdm_pkg::S_SQ:    state_d = agdm_pkg::S_METER;
      agdm_pkg::S_METER: state_d = agdm_pkg::S_EMIT;
      agdm_pkg::S_EMIT: begin
        if (out_load) begin
          state_d = agdm_pkg::S_IDLE;
        end
      end
      default: state_d = agdm_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: sv/agdm_mul.sv
// shared signed multiplier with registered product
// used by the sequencer for gain, blocker feedback and squaring
// depends on agdm_pkg
module agdm_mul (
  input  logic                                   clk_i,
  input  logic signed [agdm_pkg::MUL_A_W-1:0]    a_i,
  input  logic signed [agdm_pkg::MUL_B_W-1:0]    b_i,
  output logic signed [agdm_pkg::PROD_W-1:0]     p_o
);

  logic signed [agdm_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: sv/agdm_checker.sv
// port level checks for the audio gain, dc blocker and level meter
// bound to the top level; depends on agdm_pkg
module agdm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tlast,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [agdm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input logic                                m_axis_tuser,
  input logic                                m_axis_tlast
);

  // a chunk end word always produces output, so ready drops right after it is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken while previous word still in work");

  // a word without chunk end always carries a kept sample
  a_word_has_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
    else $error("output word with neither sample nor chunk end");

  // level fields are zero outside chunk end
  a_levels_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[122:32] == '0))
    else $error("level fields set on a word without chunk end");

  // an empty chunk reports no level
  a_empty_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && (m_axis_tdata[122:110] == '0))
      |-> (m_axis_tdata[109:32] == '0))
    else $error("levels reported for an empty chunk");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

endmodule

bind audio_gain_dc_block_meter agdm_checker u_agdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
